[rtl/rhr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhr_pkg: shared types and constants for the randomized Hadamard rotation
// Sizes, commands, sequencer states and the memory port bundles.
// ----------------------------------------------------------------------------
package rhr_pkg;

	// Sizing
	localparam int MAX_LENGTH  = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_W      = $clog2(MAX_LENGTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int K_W         = $clog2(ADDR_W + 1);
	localparam int DIM_W       = 9;
	localparam int IDX_W       = 8;
	localparam int COEF_W      = 21;
	localparam int IN_W        = (SAMPLE_BITS > COEF_W) ? SAMPLE_BITS : COEF_W;
	// sign flip adds one bit, each butterfly stage one more
	localparam int WORK_W      = IN_W + 1 + ADDR_W;

	// Scaling: Q16 multiplier, 1/sqrt(2) for odd log2 length
	localparam int                 MUL_W         = 17;
	localparam int                 FRAC_BITS     = 16;
	localparam logic [MUL_W-1:0]   INV_SQRT2_Q16 = MUL_W'(46341);
	localparam logic [MUL_W-1:0]   UNIT_Q16      = MUL_W'(65536);

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

	typedef logic signed [WORK_W-1:0] work_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	localparam coef_t   COEF_MAX     = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t   COEF_MIN     = {1'b1, {(COEF_W-1){1'b0}}};
	localparam longint  COEF_LIM     = longint'(1) << (COEF_W - 1);
	localparam work_t   WORK_COEF_HI = work_t'(COEF_MAX);
	localparam work_t   WORK_COEF_LO = work_t'(COEF_MIN);

	typedef enum logic [1:0] {
		CMD_SIGN   = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_RUN    = 2'd2,
		CMD_READ   = 2'd3
	} cmd_e;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SGN_RD,
		ST_SGN_WR,
		ST_BF_RD,
		ST_BF_WR0,
		ST_BF_WR1,
		ST_SC_RD,
		ST_SC_MUL,
		ST_SC_WR
	} state_e;

	// Work buffer write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		work_t             data;
	} wr_port_t;

	// Work buffer read ports
	typedef struct packed {
		logic              re_a;
		logic              re_b;
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
	} rd_req_t;

	// Clamp a work value to the coefficient range
	function automatic coef_t sat_coef(input work_t v);
		if (v > WORK_COEF_HI) begin
			return COEF_MAX;
		end else if (v < WORK_COEF_LO) begin
			return COEF_MIN;
		end
		return v[COEF_W-1:0];
	endfunction

endpackage

[rtl/rhr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhr_if: channel interfaces of the randomized Hadamard rotation
// Command channel, result channel and the source_dim write channel.
// ----------------------------------------------------------------------------
interface rhr_req_if;
	import rhr_pkg::*;
	logic                          valid;
	logic                          ready;
	cmd_e                          cmd;
	logic [IDX_W-1:0]              index;
	logic                          sign_negative;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, cmd, index, sign_negative, sample, input ready);
	modport sink (input valid, cmd, index, sign_negative, sample, output ready);
endinterface

interface rhr_rsp_if;
	import rhr_pkg::*;
	logic             valid;
	logic             ready;
	coef_t            coefficient;
	logic [IDX_W-1:0] out_index;

	modport source (output valid, coefficient, out_index, input ready);
	modport sink (input valid, coefficient, out_index, output ready);
endinterface

interface rhr_cfg_if;
	import rhr_pkg::*;
	logic             valid;
	logic             ready;
	logic [DIM_W-1:0] source_dim;

	modport source (output valid, source_dim, input ready);
	modport sink (input valid, source_dim, output ready);
endinterface

[rtl/rhr_work_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhr_work_mem: work buffer, one write port and two registered read ports
// Per-entry valid bits make every entry read as zero after reset.
// ----------------------------------------------------------------------------
module rhr_work_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  rhr_pkg::wr_port_t wr,
	input  rhr_pkg::rd_req_t  rd,
	output rhr_pkg::work_t    rd_a,
	output rhr_pkg::work_t    rd_b
);
	import rhr_pkg::*;

	work_t                 mem [MAX_LENGTH];
	logic [MAX_LENGTH-1:0] vld_q;
	logic                  vld_a_q;
	logic                  vld_b_q;
	work_t                 raw_a_q;
	work_t                 raw_b_q;

	// Valid bits and their read copies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd.re_a) begin
				vld_a_q <= vld_q[rd.addr_a];
			end
			if (rd.re_b) begin
				vld_b_q <= vld_q[rd.addr_b];
			end
		end
	end

	// Storage array
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.re_a) begin
			raw_a_q <= mem[rd.addr_a];
		end
		if (rd.re_b) begin
			raw_b_q <= mem[rd.addr_b];
		end
	end

	assign rd_a = vld_a_q ? raw_a_q : '0;
	assign rd_b = vld_b_q ? raw_b_q : '0;

endmodule

[rtl/rhr_scaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhr_scaler: 1/sqrt(length) scaling of one butterfly output
// Registered magnitude multiply, then round half away from zero and clamp.
// ----------------------------------------------------------------------------
module rhr_scaler (
	input  logic                    clk,
	input  logic                    en,
	input  rhr_pkg::work_t          value,
	input  logic [rhr_pkg::K_W-1:0] k,
	output rhr_pkg::coef_t          coef
);
	import rhr_pkg::*;

	localparam int PROD_W = WORK_W + MUL_W;
	localparam int RND_W  = PROD_W + 1;
	localparam int SH_W   = $clog2(FRAC_BITS + ADDR_W / 2 + 1);

	logic [WORK_W-1:0] mag;
	logic [MUL_W-1:0]  mul;
	logic [PROD_W-1:0] prod_s1;
	logic              neg_s1;
	logic [SH_W-1:0]   sh;
	logic [RND_W-1:0]  rnd;
	logic [RND_W-1:0]  r;
	logic [COEF_W-1:0] r_lo;

	// Magnitude and multiplier select
	always_comb begin
		mag = value[WORK_W-1] ? WORK_W'(-value) : WORK_W'(value);
		mul = k[0] ? INV_SQRT2_Q16 : UNIT_Q16;
	end

	// Product register
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(mag) * PROD_W'(mul);
			neg_s1  <= value[WORK_W-1];
		end
	end

	// Rounding shift and saturation
	always_comb begin
		sh   = SH_W'(FRAC_BITS) + SH_W'(k >> 1);
		rnd  = {1'b0, prod_s1} + (RND_W'(1) << (sh - 1'b1));
		r    = rnd >> sh;
		r_lo = r[COEF_W-1:0];
		if (neg_s1) begin
			if (r > RND_W'(COEF_LIM)) begin
				coef = COEF_MIN;
			end else begin
				coef = $signed(-r_lo);
			end
		end else begin
			if (r > RND_W'(COEF_LIM - 1)) begin
				coef = COEF_MAX;
			end else begin
				coef = $signed(r_lo);
			end
		end
	end

endmodule

[rtl/randomized_hadamard_rotation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// randomized_hadamard_rotation: sign flip, Walsh-Hadamard butterfly, scaling
// Sign table and work buffer in memory; a sequencer runs the rotation.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  req     | in  | cmd, index, sign_negative, sample
//  rsp     | out | coefficient, out_index (read commands only)
//  cfg     | in  | source_dim
//
//  Sign writes, sample writes and reads are taken back to back; a read beat
//  passes the work buffer and result registers to rsp; a run holds req.
//  A run (L = 2^k) reads, signs and writes each entry; reads each butterfly
//  pair, writes it twice (one write port); reads, scales, writes each entry.
//  Reset clears both tables at once through per-entry valid bits.
//  With rsp stalled one more read is taken, then req stalls.
// ----------------------------------------------------------------------------
module randomized_hadamard_rotation (
	input logic       clk,
	input logic       arst_n,
	rhr_req_if.sink   req,
	rhr_rsp_if.source rsp,
	rhr_cfg_if.sink   cfg
);
	import rhr_pkg::*;

	state_e            st_q;
	state_e            st_d;
	logic [DIM_W-1:0]  dim_q;
	logic [K_W-1:0]    k_q;
	logic [K_W-1:0]    k_run;
	logic [K_W-1:0]    hs_q;
	logic [CNT_W-1:0]  d_q;
	logic [CNT_W-1:0]  d_run;
	logic [CNT_W-1:0]  dm1;
	logic [ADDR_W-1:0] lm1_q;
	logic [ADDR_W-1:0] lm1_run;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] pair_q;
	logic [ADDR_W-1:0] lo_mask;
	logic [ADDR_W-1:0] hbit;
	logic [ADDR_W-1:0] bf_lo;
	logic [ADDR_W-1:0] bf_hi;
	logic [ADDR_W-1:0] req_addr;
	logic              idx_last;
	logic              pair_last;
	logic              hs_last;
	logic              req_acc;
	logic              req_in_range;
	logic              run_start;
	logic              pend_s1;
	logic              pend_rng_s1;
	logic [IDX_W-1:0]  pend_idx_s1;
	logic              pend_move;
	logic              rsp_vld_q;
	coef_t             coef_q;
	logic [IDX_W-1:0]  oidx_q;
	wr_port_t          wr;
	rd_req_t           rd;
	work_t             rd_a;
	work_t             rd_b;
	work_t             diff_q;
	work_t             sgn_val;
	logic              sc_en;
	coef_t             sc_coef;
	logic              sgn_mem [MAX_LENGTH];
	logic [MAX_LENGTH-1:0] sgn_vld_q;
	logic              sgn_raw_q;
	logic              sgn_rvld_q;
	logic              sgn_re;
	logic              sgn_neg;

	// Handshakes
	assign pend_move    = pend_s1 && (!rsp_vld_q || rsp.ready);
	assign req.ready    = (st_q == ST_IDLE) && (!pend_s1 || !rsp_vld_q || rsp.ready);
	assign req_acc      = req.valid && req.ready;
	assign req_in_range = int'(req.index) < MAX_LENGTH;
	assign req_addr     = ADDR_W'(req.index);
	assign run_start    = req_acc && (req.cmd == CMD_RUN);
	assign cfg.ready    = 1'b1;

	// Rotated length from source_dim
	always_comb begin
		k_run = '0;
		if (int'(dim_q) > MAX_LENGTH) begin
			d_run = CNT_W'(MAX_LENGTH);
		end else begin
			d_run = CNT_W'(dim_q);
		end
		dm1 = d_run - 1'b1;
		if (d_run > CNT_W'(1)) begin
			for (int b = 0; b < CNT_W; b++) begin
				if (dm1[b]) begin
					k_run = K_W'(b + 1);
				end
			end
		end
		lm1_run = ADDR_W'((CNT_W'(1) << k_run) - 1'b1);
	end

	// Butterfly pair addresses: insert a zero at bit hs of the pair count
	always_comb begin
		hbit    = ADDR_W'(1) << hs_q;
		lo_mask = hbit - 1'b1;
		bf_lo   = ((pair_q & ~lo_mask) << 1) | (pair_q & lo_mask);
		bf_hi   = bf_lo | hbit;
	end

	assign idx_last  = idx_q == lm1_q;
	assign pair_last = pair_q == (lm1_q >> 1);
	assign hs_last   = hs_q == K_W'(k_q - 1'b1);

	// Signed and padded entry for the first pass
	assign sgn_neg = sgn_rvld_q && sgn_raw_q;
	always_comb begin
		if ({1'b0, idx_q} < d_q) begin
			sgn_val = sgn_neg ? -rd_a : rd_a;
		end else begin
			sgn_val = '0;
		end
	end

	// Sequencer next state and memory controls
	always_comb begin
		st_d   = st_q;
		wr     = '0;
		rd     = '0;
		sc_en  = 1'b0;
		sgn_re = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (req_acc) begin
					case (req.cmd)
						CMD_SAMPLE: begin
							wr.en   = req_in_range;
							wr.addr = req_addr;
							wr.data = work_t'(req.sample);
						end
						CMD_RUN: begin
							st_d = ST_SGN_RD;
						end
						CMD_READ: begin
							rd.re_a   = 1'b1;
							rd.addr_a = req_addr;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SGN_RD: begin
				rd.re_a   = 1'b1;
				rd.addr_a = idx_q;
				sgn_re    = 1'b1;
				st_d      = ST_SGN_WR;
			end
			ST_SGN_WR: begin
				wr.en   = 1'b1;
				wr.addr = idx_q;
				wr.data = sgn_val;
				if (idx_last) begin
					st_d = (k_q == '0) ? ST_SC_RD : ST_BF_RD;
				end else begin
					st_d = ST_SGN_RD;
				end
			end
			ST_BF_RD: begin
				rd.re_a   = 1'b1;
				rd.re_b   = 1'b1;
				rd.addr_a = bf_lo;
				rd.addr_b = bf_hi;
				st_d      = ST_BF_WR0;
			end
			ST_BF_WR0: begin
				wr.en   = 1'b1;
				wr.addr = bf_lo;
				wr.data = rd_a + rd_b;
				st_d    = ST_BF_WR1;
			end
			ST_BF_WR1: begin
				wr.en   = 1'b1;
				wr.addr = bf_hi;
				wr.data = diff_q;
				st_d    = (pair_last && hs_last) ? ST_SC_RD : ST_BF_RD;
			end
			ST_SC_RD: begin
				rd.re_a   = 1'b1;
				rd.addr_a = idx_q;
				st_d      = ST_SC_MUL;
			end
			ST_SC_MUL: begin
				sc_en = 1'b1;
				st_d  = ST_SC_WR;
			end
			ST_SC_WR: begin
				wr.en   = 1'b1;
				wr.addr = idx_q;
				wr.data = work_t'(sc_coef);
				st_d    = idx_last ? ST_IDLE : ST_SC_RD;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// State, run length and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			dim_q  <= DIM_RESET;
			k_q    <= '0;
			d_q    <= '0;
			lm1_q  <= '0;
			idx_q  <= '0;
			pair_q <= '0;
			hs_q   <= '0;
		end else begin
			st_q <= st_d;
			if (cfg.valid && cfg.ready) begin
				dim_q <= cfg.source_dim;
			end
			case (st_q)
				ST_IDLE: begin
					if (run_start) begin
						k_q   <= k_run;
						d_q   <= d_run;
						lm1_q <= lm1_run;
						idx_q <= '0;
					end
				end
				ST_SGN_WR: begin
					if (idx_last) begin
						idx_q  <= '0;
						pair_q <= '0;
						hs_q   <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_BF_WR1: begin
					if (pair_last) begin
						pair_q <= '0;
						hs_q   <= hs_q + 1'b1;
					end else begin
						pair_q <= pair_q + 1'b1;
					end
				end
				ST_SC_WR: begin
					idx_q <= idx_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Butterfly difference held for the second write
	always_ff @(posedge clk) begin
		if (st_q == ST_BF_WR0) begin
			diff_q <= rd_a - rd_b;
		end
	end

	// Sign table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sgn_vld_q  <= '0;
			sgn_rvld_q <= 1'b0;
		end else begin
			if (req_acc && (req.cmd == CMD_SIGN) && req_in_range) begin
				sgn_vld_q[req_addr] <= 1'b1;
			end
			if (sgn_re) begin
				sgn_rvld_q <= sgn_vld_q[idx_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && (req.cmd == CMD_SIGN) && req_in_range) begin
			sgn_mem[req_addr] <= req.sign_negative;
		end
		if (sgn_re) begin
			sgn_raw_q <= sgn_mem[idx_q];
		end
	end

	rhr_work_mem u_work_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (wr),
		.rd    (rd),
		.rd_a  (rd_a),
		.rd_b  (rd_b)
	);

	rhr_scaler u_scaler (
		.clk  (clk),
		.en   (sc_en),
		.value(rd_a),
		.k    (k_q),
		.coef (sc_coef)
	);

	// Read pipeline and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1   <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			pend_s1 <= (req_acc && (req.cmd == CMD_READ)) || (pend_s1 && !pend_move);
			if (pend_move) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && (req.cmd == CMD_READ)) begin
			pend_idx_s1 <= req.index;
			pend_rng_s1 <= req_in_range;
		end
		if (pend_move) begin
			coef_q <= pend_rng_s1 ? sat_coef(rd_a) : '0;
			oidx_q <= pend_idx_s1;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.coefficient = coef_q;
	assign rsp.out_index   = oidx_q;

	// Checks
	a_run_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !pend_s1)
		else $error("read pending during a run");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.cmd == CMD_RUN)) |=> (st_q == ST_SGN_RD))
		else $error("run command did not start the sign pass");

	a_bf_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_BF_WR1) |-> (((bf_lo & hbit) == '0) && ((bf_hi & hbit) != '0)))
		else $error("butterfly pair addresses malformed");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(pend_s1))
		else $error("result beat without a pending read");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for randomized_hadamard_rotation
// Drives sign writes, sample writes, rotation runs and coefficient reads with
// random gaps on the command side and random stalls on the result side. A
// scoreboard keeps its own sign table and work buffer, predicts every read
// and checks each result beat in order. source_dim is swept across its
// extremes between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
	import rhr_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 2000000;
	localparam int          RANDOM_ITEMS = 500;

	// Expected coefficient read beat
	typedef struct {
		coef_t            coef;
		logic [IDX_W-1:0] idx;
	} coef_exp_t;

	// Scoreboard: shadow sign table and work buffer, queue of pending reads
	class coef_scoreboard;
		bit            signs[MAX_LENGTH];
		longint        work[MAX_LENGTH];
		int unsigned   dim;
		coef_exp_t     coef_q[$];
		int            errors;
		int            beats;
		int            runs;
		int            reads;

		function new();
			for (int i = 0; i < MAX_LENGTH; i++) begin
				signs[i] = 1'b0;
				work[i]  = 0;
			end
			dim    = DIM_RESET;
			errors = 0;
			beats  = 0;
			runs   = 0;
			reads  = 0;
		endfunction

		function void set_dim(logic [DIM_W-1:0] v);
			dim = v;
		endfunction

		function int pending();
			return coef_q.size();
		endfunction

		// Rotated length, its log2 and the number of samples that take part
		function void shape(output int unsigned len, output int unsigned k,
				output int unsigned d_used);
			d_used = (dim > MAX_LENGTH) ? MAX_LENGTH : dim;
			len    = 1;
			k      = 0;
			while (len < d_used && (len << 1) <= MAX_LENGTH) begin
				len = len << 1;
				k++;
			end
			if (d_used > len) begin
				d_used = len;
			end
		endfunction

		function longint clamp_coef(longint v);
			if (v > COEF_LIM - 1) begin
				return COEF_LIM - 1;
			end else if (v < -COEF_LIM) begin
				return -COEF_LIM;
			end
			return v;
		endfunction

		// Sign flip, zero pad, butterfly, 1/sqrt(L) scaling with rounding
		function void rotate();
			longint      t[MAX_LENGTH];
			longint      x, y, v, mag, r, mul;
			int unsigned len, k, d_used, h, i, j, s;
			shape(len, k, d_used);
			for (i = 0; i < len; i++) begin
				if (i < d_used) begin
					t[i] = signs[i] ? -work[i] : work[i];
				end else begin
					t[i] = 0;
				end
			end
			for (h = 1; h < len; h = h << 1) begin
				for (i = 0; i < len; i += (h << 1)) begin
					for (j = i; j < i + h; j++) begin
						x        = t[j];
						y        = t[j + h];
						t[j]     = x + y;
						t[j + h] = x - y;
					end
				end
			end
			mul = k[0] ? longint'(INV_SQRT2_Q16) : longint'(UNIT_Q16);
			s   = FRAC_BITS + (k >> 1);
			for (i = 0; i < len; i++) begin
				v       = t[i];
				mag     = (v < 0) ? -v : v;
				r       = (mag * mul + (longint'(1) << (s - 1))) >> s;
				work[i] = clamp_coef((v < 0) ? -r : r);
			end
		endfunction

		// Accepted command beat: update shadow state, queue a read result
		function void note_input(cmd_e op, logic [IDX_W-1:0] idx, logic sgn,
				logic signed [SAMPLE_BITS-1:0] smp);
			coef_exp_t e;
			beats++;
			case (op)
				CMD_SIGN: begin
					signs[idx] = sgn;
				end
				CMD_SAMPLE: begin
					work[idx] = longint'(smp);
				end
				CMD_RUN: begin
					runs++;
					rotate();
				end
				default: begin
					e.coef = coef_t'(clamp_coef(work[idx]));
					e.idx  = idx;
					coef_q.push_back(e);
				end
			endcase
		endfunction

		// Result beat against the oldest expected read
		function void check_result(coef_t coef, logic [IDX_W-1:0] idx);
			coef_exp_t e;
			if (coef_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected: coefficient %0d index %0d",
					$time, coef, idx);
				return;
			end
			e = coef_q.pop_front();
			reads++;
			if (coef !== e.coef) begin
				errors++;
				$display("%0t: coefficient mismatch: expected %0d, actual %0d (index %0d)",
					$time, e.coef, coef, e.idx);
			end
			if (idx !== e.idx) begin
				errors++;
				$display("%0t: out_index mismatch: expected %0d, actual %0d",
					$time, e.idx, idx);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rhr_req_if req_ch ();
	rhr_rsp_if rsp_ch ();
	rhr_cfg_if cfg_ch ();

	randomized_hadamard_rotation dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	coef_scoreboard sb = new();

	int unsigned cycles    = 0;
	bit          calm      = 1'b0;
	int          dim_sets  = 0;

	// Clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb failed");
			$finish;
		end
	end

	// Result side: random stall before each beat, none in calm phases
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			sb.check_result(rsp_ch.coefficient, rsp_ch.out_index);
		end
	end

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// One command beat; fields the command ignores carry random values
	task automatic send(cmd_e op, int idx, logic sgn, logic signed [SAMPLE_BITS-1:0] smp);
		int                            gap;
		logic [IDX_W-1:0]              i_v;
		logic                          s_v;
		logic signed [SAMPLE_BITS-1:0] d_v;
		gap = calm ? 0 : $urandom_range(0, 10);
		i_v = (op == CMD_RUN) ? IDX_W'($urandom) : IDX_W'(idx);
		s_v = (op == CMD_SIGN) ? sgn : 1'($urandom);
		d_v = (op == CMD_SAMPLE) ? smp : SAMPLE_BITS'($urandom);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.cmd           <= op;
		req_ch.index         <= i_v;
		req_ch.sign_negative <= s_v;
		req_ch.sample        <= d_v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_input(op, i_v, s_v, d_v);
	endtask

	// Wait until every read has returned and any run in flight is done
	task automatic quiesce();
		int unsigned len, k, d_used;
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		sb.shape(len, k, d_used);
		repeat (2 * len + 3 * (len / 2) * k + 3 * len + 16) @(posedge clk);
	endtask

	task automatic write_dim(logic [DIM_W-1:0] v);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.source_dim <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		sb.set_dim(v);
		dim_sets++;
	endtask

	// Occasional stray beat; runs only where the rotated length is short
	task automatic maybe_noise();
		cmd_e        op;
		int unsigned len, k, d_used;
		if ($urandom_range(0, 6) == 0) begin
			sb.shape(len, k, d_used);
			op = cmd_e'($urandom_range(0, 3));
			if (op == CMD_RUN && len > 32) begin
				op = CMD_READ;
			end
			send(op, $urandom_range(0, MAX_LENGTH - 1), 1'($urandom), rand_sample());
		end
	endtask

	// Fill signs and samples, rotate, read back; extremes of source_dim first
	task automatic rand_sequence(int seq);
		logic [DIM_W-1:0] dim;
		int unsigned      len, k, d_used, keep, n_fill;
		case (seq)
			0: dim = DIM_W'(0);
			1: dim = DIM_W'(1);
			2: dim = {DIM_W{1'b1}};
			3: dim = DIM_W'(2);
			4: dim = DIM_W'(MAX_LENGTH + 1);
			5: dim = DIM_W'(3);
			6: dim = DIM_W'(MAX_LENGTH);
			7: dim = DIM_W'(MAX_LENGTH / 2);
			default: begin
				case ($urandom_range(0, 9))
					0: dim = DIM_W'($urandom_range(17, MAX_LENGTH));
					1: dim = DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
					default: dim = DIM_W'($urandom_range(1, 16));
				endcase
			end
		endcase
		quiesce();
		write_dim(dim);
		calm = ($urandom_range(0, 3) == 0);
		sb.shape(len, k, d_used);
		keep   = (len > 64) ? 8 : 1;
		n_fill = (d_used == 0) ? 1 : d_used;

		for (int i = 0; i < d_used; i++) begin
			if ($urandom_range(1, keep) == 1) begin
				send(CMD_SIGN, i, 1'($urandom), rand_sample());
				maybe_noise();
			end
		end
		for (int i = 0; i < n_fill; i++) begin
			if ($urandom_range(1, keep) == 1) begin
				send(CMD_SAMPLE, i, 1'($urandom), rand_sample());
				maybe_noise();
			end
		end
		// samples in the padded region and past the rotated length
		if (d_used < len && $urandom_range(0, 1) == 0) begin
			send(CMD_SAMPLE, $urandom_range(d_used, len - 1), 1'b0, rand_sample());
		end
		if (len < MAX_LENGTH && $urandom_range(0, 1) == 0) begin
			send(CMD_SAMPLE, $urandom_range(len, MAX_LENGTH - 1), 1'b0, rand_sample());
		end

		send(CMD_RUN, 0, 1'b0, '0);
		if ($urandom_range(0, 3) == 0) begin
			send(CMD_RUN, 0, 1'b0, '0);
		end

		for (int i = 0; i < len; i++) begin
			if ($urandom_range(1, keep) == 1) begin
				send(CMD_READ, i, 1'b0, '0);
				maybe_noise();
			end
		end
		send(CMD_READ, $urandom_range(0, MAX_LENGTH - 1), 1'b0, '0);
		send(CMD_READ, $urandom_range(len - 1, MAX_LENGTH - 1), 1'b0, '0);
	endtask

	// Main sequence
	initial begin
		int start_beats;
		int seq;
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.cmd           <= CMD_SIGN;
		req_ch.index         <= '0;
		req_ch.sign_negative <= 1'b0;
		req_ch.sample        <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.source_dim    <= DIM_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads after reset, extreme samples, read before run,
		// a full-length run and a repeated run
		send(CMD_READ, 0, 1'b0, '0);
		send(CMD_READ, MAX_LENGTH - 1, 1'b0, '0);
		send(CMD_SAMPLE, 0, 1'b0, 16'sh7fff);
		send(CMD_SAMPLE, MAX_LENGTH - 1, 1'b0, 16'sh8000);
		send(CMD_SAMPLE, 1, 1'b0, -16'sd1);
		send(CMD_SAMPLE, MAX_LENGTH / 2, 1'b0, 16'sd1);
		send(CMD_SIGN, MAX_LENGTH - 1, 1'b1, '0);
		send(CMD_SIGN, 1, 1'b1, '0);
		send(CMD_SIGN, 0, 1'b0, '0);
		send(CMD_READ, 0, 1'b0, '0);
		send(CMD_READ, MAX_LENGTH - 1, 1'b0, '0);
		send(CMD_RUN, 0, 1'b0, '0);
		send(CMD_READ, 0, 1'b0, '0);
		send(CMD_READ, 1, 1'b0, '0);
		send(CMD_READ, MAX_LENGTH / 2, 1'b0, '0);
		send(CMD_READ, MAX_LENGTH - 1, 1'b0, '0);
		send(CMD_RUN, 0, 1'b0, '0);
		send(CMD_READ, 0, 1'b0, '0);
		send(CMD_READ, MAX_LENGTH - 1, 1'b0, '0);

		// Random phases
		start_beats = sb.beats;
		seq         = 0;
		while (sb.beats - start_beats < RANDOM_ITEMS) begin
			rand_sequence(seq);
			seq++;
		end

		// Drain
		calm = 1'b0;
		quiesce();

		$display("covered %0d command beats with %0d rotation runs over %0d source_dim settings",
			sb.beats, sb.runs, dim_sets);
		$display("checked %0d coefficient reads, %0d errors", sb.reads, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
